@@ sv/fqsq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the scan queue.
`timescale 1ns / 1ps

package fqsq_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 9;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MIN    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_MAX    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic step;
      logic finish;
   } fqsq_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } fqsq_stat_type;

endpackage

@@ sv/fqsq_ctrl.sv @@
// Sequencing state machine for the scan queue.
`timescale 1ns / 1ps

module fqsq_ctrl
   import fqsq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  fqsq_stat_type stat,
   output fqsq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_scan ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ sv/fqsq_dp.sv @@
// Ring store, head/count registers, scan engine and result registers of the scan queue.
`timescale 1ns / 1ps

module fqsq_dp
   import fqsq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fqsq_cmd_type               cmd,
   output fqsq_stat_type              stat,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_extreme,
   output logic [CNT_W-1:0]           rsp_match_count,
   output logic                       rsp_found,
   output logic [CNT_W-1:0]           rsp_occupancy
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W + 1) ? CW : POS_W + 1;

   logic [VALUE_W-1:0] mem [DEPTH];

   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         matches_ff, matches_in;
   logic [VALUE_W-1:0]    best_ff, best_in;
   logic                  first_ff, first_in;
   logic                  pend_ff;
   logic [VALUE_W-1:0]    rd_data_ff;
   logic [AW-1:0]         wr_slot_ff;

   logic                  strobe_ff, strobe_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [VALUE_W-1:0]    extreme_ff, extreme_in;
   logic [CNT_W-1:0]      mcount_ff, mcount_in;
   logic                  found_ff, found_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;

   logic                  empty;
   logic                  full;
   logic [XW-1:0]         pos_x;
   logic [XW-1:0]         cnt_x;
   logic                  is_scan_kind;
   logic                  is_remove;
   logic                  better;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [VALUE_W-1:0]    mem_wdata;
   logic [AW-1:0]         rd_slot;

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign empty        = (count_ff == '0);
   assign full         = (count_ff == CW'(DEPTH));
   assign pos_x        = XW'(pos_ff);
   assign cnt_x        = XW'(count_ff);
   assign is_remove    = (kind_ff == KIND_REMOVE);
   assign is_scan_kind = (kind_ff == KIND_COUNT) || (kind_ff == KIND_MIN) ||
                         (kind_ff == KIND_MAX);

   assign stat.need_scan = !empty && (is_scan_kind || (is_remove && (pos_x + XW'(1) < cnt_x)));
   assign stat.scan_last = (idx_ff == count_ff - CW'(1));

   assign rd_slot = slot(head_ff, idx_ff);

   assign better = (kind_ff == KIND_MIN) ? ($signed(rd_data_ff) < $signed(best_ff))
                                         : ($signed(rd_data_ff) > $signed(best_ff));

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      matches_in = matches_ff;
      best_in    = best_ff;
      first_in   = first_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      extreme_in = extreme_ff;
      mcount_in  = mcount_ff;
      found_in   = found_ff;
      occ_in     = occ_ff;
      mem_we     = 1'b0;
      mem_waddr  = wr_slot_ff;
      mem_wdata  = rd_data_ff;

      if (cmd.capture) begin
         kind_in  = req_kind;
         value_in = req_value;
         pos_in   = req_position;
      end

      if (cmd.exec) begin
         if (stat.need_scan) begin
            idx_in     = is_remove ? CW'(pos_x + XW'(1)) : '0;
            matches_in = '0;
            first_in   = 1'b1;
         end else begin
            status_in  = ST_OK;
            extreme_in = '0;
            mcount_in  = '0;
            found_in   = 1'b0;
            case (kind_ff)
               KIND_PUSH: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = slot(head_ff, count_ff);
                     mem_wdata = value_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end
               KIND_POP: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     head_in  = slot(head_ff, CW'(1));
                     count_in = count_ff - CW'(1);
                  end
               end
               KIND_CLEAR: begin
                  head_in  = '0;
                  count_in = '0;
               end
               KIND_COUNT, KIND_MIN, KIND_MAX: begin
                  status_in = ST_EMPTY;
               end
               KIND_REMOVE: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else if (pos_x >= cnt_x) begin
                     status_in = ST_BADPOS;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
            occ_in    = CNT_W'(count_in);
            strobe_in = 1'b1;
         end
      end

      if (cmd.step) begin
         idx_in = idx_ff + CW'(1);
      end

      if (pend_ff) begin
         if (is_remove) begin
            mem_we = 1'b1;
         end
         if (rd_data_ff == value_ff) begin
            matches_in = matches_ff + CW'(1);
         end
         if (first_ff || better) begin
            best_in = rd_data_ff;
         end
         first_in = 1'b0;
      end

      if (cmd.finish) begin
         status_in  = ST_OK;
         extreme_in = '0;
         mcount_in  = '0;
         found_in   = 1'b0;
         if (is_remove) begin
            count_in = count_ff - CW'(1);
         end else if (kind_ff == KIND_COUNT) begin
            mcount_in = CNT_W'(matches_ff);
            found_in  = (matches_ff != '0);
         end else begin
            extreme_in = best_ff;
         end
         occ_in    = CNT_W'(count_in);
         strobe_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_slot];
      wr_slot_ff <= slot(head_ff, idx_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         pend_ff   <= cmd.step;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      matches_ff <= matches_in;
      best_ff    <= best_in;
      first_ff   <= first_in;
      status_ff  <= status_in;
      extreme_ff <= extreme_in;
      mcount_ff  <= mcount_in;
      found_ff   <= found_in;
      occ_ff     <= occ_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_extreme     = extreme_ff;
   assign rsp_match_count = mcount_ff;
   assign rsp_found       = found_ff;
   assign rsp_occupancy   = occ_ff;

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)) && (32'(head_ff) < 32'(DEPTH)))
      else $error("queue head or count out of range");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (idx_ff < count_ff))
      else $error("scan reads past occupancy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("back-to-back result strobes");

   a_pend_follows_step: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.step))
      else $error("read data marked without a read");

endmodule

@@ sv/fifo_queue_with_scan_queries_unit.sv @@
// Top level of the bounded FIFO with count, minimum, maximum and positional removal.
// Push, pop, clear and every refused request: the result is set in the execute state and its strobe is registered.
// Count, minimum and maximum scan every stored entry; removal at p moves each entry behind p down one place.
// The scans run one stored entry per cycle through the single read port of the ring store.
// A new request is taken once busy is low, which already holds during the result strobe.
// Synchronous reset empties the queue; entries are undefined until pushed.
`timescale 1ns / 1ps

module fifo_queue_with_scan_queries_unit
   import fqsq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_extreme,
   output logic [CNT_W-1:0]           rsp_match_count,
   output logic                       rsp_found,
   output logic [CNT_W-1:0]           rsp_occupancy
);

   fqsq_cmd_type  cmd;
   fqsq_stat_type stat;

   fqsq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fqsq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_extreme     (rsp_extreme),
      .rsp_match_count (rsp_match_count),
      .rsp_found       (rsp_found),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule
